### rtl/gil_pkg.sv
`timescale 1ns / 1ps

package gil_pkg;

    // input item function codes
    localparam logic [1:0] FUNC_RANGE  = 2'd0;
    localparam logic [1:0] FUNC_SPARSE = 2'd1;
    localparam logic [1:0] FUNC_LOOKUP = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_RANGE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_SPARSE_COUNT = 2'd1;
    localparam logic [1:0] CFG_GLYPH_COUNT  = 2'd2;

    // lookup token walking the range cells
    typedef struct packed {
        logic        valid;
        logic [15:0] code;
        logic [31:0] total;
        logic        hit;
        logic [31:0] idx;
    } t_token;

    // finished search handed to the output stage
    typedef struct packed {
        logic        valid;
        logic        hit;
        logic [31:0] idx;
    } t_result;

endpackage

### rtl/gil_range_cell.sv
`timescale 1ns / 1ps

module gil_range_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr_en,
    input  logic [15:0]     i_first,
    input  logic [15:0]     i_last,
    input  logic            i_active,
    input  gil_pkg::t_token i_tok,
    output gil_pkg::t_token o_tok
);
    import gil_pkg::*;

    logic [15:0] r_first;
    logic [15:0] r_last;
    t_token      r_tok;
    t_token      n_tok;

    // stored range entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_first <= i_first;
            r_last  <= i_last;
        end
    end

    // test the code against this range, else add its length to the total
    always_comb begin
        n_tok = i_tok;
        if (i_tok.valid && i_active && !i_tok.hit) begin
            if (i_tok.code >= r_first && i_tok.code <= r_last) begin
                n_tok.hit = 1'b1;
                n_tok.idx = i_tok.total + {16'd0, i_tok.code - r_first};
            end else begin
                n_tok.total = i_tok.total + {16'd0, r_last} - {16'd0, r_first} + 32'd1;
            end
        end
    end

    // hand the token to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.code  <= n_tok.code;
        r_tok.total <= n_tok.total;
        r_tok.hit   <= n_tok.hit;
        r_tok.idx   <= n_tok.idx;
    end

    assign o_tok = r_tok;

endmodule

### rtl/gil_search.sv
`timescale 1ns / 1ps

module gil_search #(
    parameter int MAX_SPARSE = 256,
    parameter int AW         = (MAX_SPARSE > 1) ? $clog2(MAX_SPARSE) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  gil_pkg::t_token  i_tok,
    input  logic [8:0]       i_sparse_count,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [15:0]      i_wr_data,
    input  logic             i_take,
    output gil_pkg::t_result o_res
);
    import gil_pkg::*;

    localparam int NSW = $clog2(MAX_SPARSE + 1);
    localparam int SW  = NSW + 1;

    typedef enum logic [1:0] {S_IDLE, S_PROBE, S_CMP, S_DONE} t_state;

    logic [15:0]          r_mem [MAX_SPARSE];
    logic [15:0]          r_rdata;
    t_state               r_state;
    logic signed [SW-1:0] r_lo;
    logic signed [SW-1:0] r_hi;
    logic [AW-1:0]        r_mid;
    logic [15:0]          r_code;
    logic [31:0]          r_total;
    logic                 r_hit;
    logic [31:0]          r_idx;
    logic [NSW-1:0]       w_ns;
    logic signed [SW-1:0] w_mid;
    logic signed [SW-1:0] w_mid_ext;

    // entries in use, clamped to the table depth
    assign w_ns = ({23'd0, i_sparse_count} > 32'(MAX_SPARSE)) ? NSW'(MAX_SPARSE)
                                                              : NSW'(i_sparse_count);

    // midpoint of the current window
    assign w_mid     = r_lo + ((r_hi - r_lo) >>> 1);
    assign w_mid_ext = $signed({{(SW - AW){1'b0}}, r_mid});

    // sparse code table
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered probe read
    always_ff @(posedge i_clk) begin
        if (r_state == S_PROBE) begin
            r_rdata <= r_mem[w_mid[AW-1:0]];
        end
    end

    // binary search sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_tok.valid) begin
                        r_code  <= i_tok.code;
                        r_total <= i_tok.total;
                        r_lo    <= '0;
                        r_hi    <= $signed({1'b0, w_ns}) - SW'(1);
                        r_hit   <= i_tok.hit;
                        r_idx   <= i_tok.idx;
                        if (i_tok.hit || w_ns == '0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_PROBE;
                        end
                    end
                end
                S_PROBE: begin
                    if (r_lo > r_hi) begin
                        r_hit   <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_mid   <= w_mid[AW-1:0];
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    if (r_rdata == r_code) begin
                        r_hit   <= 1'b1;
                        r_idx   <= r_total + 32'(r_mid);
                        r_state <= S_DONE;
                    end else if (r_rdata < r_code) begin
                        r_lo    <= w_mid_ext + SW'(1);
                        r_state <= S_PROBE;
                    end else begin
                        r_hi    <= w_mid_ext - SW'(1);
                        r_state <= S_PROBE;
                    end
                end
                S_DONE: begin
                    if (i_take) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res.valid = (r_state == S_DONE);
    assign o_res.hit   = r_hit;
    assign o_res.idx   = r_idx;

endmodule

### rtl/glyph_index_lookup.sv
`timescale 1ns / 1ps

// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_stall    i_func, i_entry_index, i_range_first,
//                                                i_range_last, i_sparse_code, i_code_point
// out      output     o_out_valid / i_out_stall  o_found, o_glyph_index
// cfg      input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// a write beat stores its entry at acceptance and its result shows in the next cycle.
// a lookup walks the MAX_RANGES range cells, one per cycle, then the binary search
// runs its probes on the registered sparse table read, each probe passing through a
// probe and a compare state: at most P probes, P = ceil(log2(sparse entries + 1)) (9 at 256).
// one item at a time; the input stalls while a lookup is in flight or the output
// holds a stalled beat. synchronous active-low reset clears counts and control,
// tables are undefined until written.

module glyph_index_lookup #(
    parameter int MAX_RANGES = 16,
    parameter int MAX_SPARSE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_entry_index,
    input  logic [15:0] i_range_first,
    input  logic [15:0] i_range_last,
    input  logic [15:0] i_sparse_code,
    input  logic [15:0] i_code_point,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_found,
    output logic [15:0] o_glyph_index,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import gil_pkg::*;

    localparam int AW = (MAX_SPARSE > 1) ? $clog2(MAX_SPARSE) : 1;

    logic [4:0]  r_range_count;
    logic [8:0]  r_sparse_count;
    logic [15:0] r_glyph_count;
    logic        r_busy;
    logic        r_out_valid;
    logic        r_found;
    logic [15:0] r_glyph_index;
    logic        w_accept;
    logic        w_out_free;
    logic        w_take;
    logic        w_sparse_we;
    t_token      w_chain [MAX_RANGES + 1];
    t_result     w_res;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_take     = w_res.valid && w_out_free;
    assign o_in_stall = r_busy || (r_out_valid && i_out_stall);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_count  <= '0;
            r_sparse_count <= '0;
            r_glyph_count  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RANGE_COUNT:  r_range_count  <= i_cfg_data[4:0];
                CFG_SPARSE_COUNT: r_sparse_count <= i_cfg_data[8:0];
                CFG_GLYPH_COUNT:  r_glyph_count  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // lookup token entering the first cell
    always_comb begin
        w_chain[0].valid = w_accept && (i_func == FUNC_LOOKUP);
        w_chain[0].code  = i_code_point;
        w_chain[0].total = '0;
        w_chain[0].hit   = 1'b0;
        w_chain[0].idx   = '0;
    end

    // row of range cells
    for (genvar k = 0; k < MAX_RANGES; k++) begin : g_cell
        logic w_wr_en;
        logic w_active;
        assign w_wr_en  = w_accept && (i_func == FUNC_RANGE)
                          && ({24'd0, i_entry_index} == 32'(k));
        assign w_active = {27'd0, r_range_count} > 32'(k);

        gil_range_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr_en  (w_wr_en),
            .i_first  (i_range_first),
            .i_last   (i_range_last),
            .i_active (w_active),
            .i_tok    (w_chain[k]),
            .o_tok    (w_chain[k + 1])
        );
    end

    assign w_sparse_we = w_accept && (i_func == FUNC_SPARSE)
                         && ({24'd0, i_entry_index} < 32'(MAX_SPARSE));

    // sparse table and binary search
    gil_search #(
        .MAX_SPARSE (MAX_SPARSE),
        .AW         (AW)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tok          (w_chain[MAX_RANGES]),
        .i_sparse_count (r_sparse_count),
        .i_wr_en        (w_sparse_we),
        .i_wr_addr      (AW'(i_entry_index)),
        .i_wr_data      (i_sparse_code),
        .i_take         (w_take),
        .o_res          (w_res)
    );

    // busy from lookup acceptance until its result is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept && (i_func == FUNC_LOOKUP)) begin
            r_busy <= 1'b1;
        end else if (w_take) begin
            r_busy <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (w_accept && (i_func != FUNC_LOOKUP)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            if (w_res.hit && (w_res.idx < {16'd0, r_glyph_count})) begin
                r_found       <= 1'b1;
                r_glyph_index <= w_res.idx[15:0];
            end else begin
                r_found       <= 1'b0;
                r_glyph_index <= '0;
            end
        end else if (w_accept && (i_func != FUNC_LOOKUP)) begin
            r_found       <= 1'b0;
            r_glyph_index <= '0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_found;
    assign o_glyph_index = r_glyph_index;

    // a search result only appears for a lookup in flight
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.valid |-> r_busy)
        else $error("search result without a lookup in flight");

    // a found glyph lies below the glyph count
    a_found_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found) |-> (o_glyph_index < r_glyph_count))
        else $error("found glyph index at or above glyph count");

    // a miss reports index zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_glyph_index == 16'd0))
        else $error("not-found beat with nonzero glyph index");

    // an accepted lookup keeps the block busy
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_func == FUNC_LOOKUP)) |=> (r_busy && !r_out_valid || r_busy))
        else $error("lookup accepted but block not busy");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import gil_pkg::*;

    localparam int N_RANGES     = 16;
    localparam int N_SPARSE     = 256;
    localparam int DRAIN_CYCLES = 80;
    localparam int QUIET_LIMIT  = 4000;
    localparam int RAND_PHASES  = 10;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  slot;
        logic [15:0] first;
        logic [15:0] last;
        logic [15:0] scode;
        logic [15:0] code;
    } t_glyph_beat;

    typedef struct packed {
        logic        found;
        logic [15:0] glyph;
    } t_glyph_res;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_func = FUNC_LOOKUP;
    logic [7:0]  i_entry_index = 8'd0;
    logic [15:0] i_range_first = 16'd0;
    logic [15:0] i_range_last = 16'd0;
    logic [15:0] i_sparse_code = 16'd0;
    logic [15:0] i_code_point = 16'd0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic        o_found;
    logic [15:0] o_glyph_index;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_RANGE_COUNT;
    logic [15:0] i_cfg_data = 16'd0;

    // shadow copy of the tables and registers
    logic [15:0] tab_first [N_RANGES];
    logic [15:0] tab_last [N_RANGES];
    logic [15:0] tab_sparse [N_SPARSE];
    logic [4:0]  cnt_ranges = 5'd0;
    logic [8:0]  cnt_sparse = 9'd0;
    logic [15:0] cnt_glyphs = 16'd0;

    t_glyph_res  pending_glyphs [$];
    int          mismatches = 0;
    int          quiet_cycles = 0;
    int          in_gap_pct = 8;
    int          out_stall_pct = 8;

    glyph_index_lookup #(
        .MAX_RANGES(N_RANGES),
        .MAX_SPARSE(N_SPARSE)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_func(i_func),
        .i_entry_index(i_entry_index),
        .i_range_first(i_range_first),
        .i_range_last(i_range_last),
        .i_sparse_code(i_sparse_code),
        .i_code_point(i_code_point),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_found(o_found),
        .o_glyph_index(o_glyph_index),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // random back-pressure on the result side
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // watchdog on cycles without any beat moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL glyph_index_lookup");
            $finish;
        end
    end

    // result checker against the oldest expectation
    always @(posedge i_clk) begin
        t_glyph_res exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_glyphs.size() == 0) begin
                $display("%0t unexpected result found %0d glyph %0d", $time, o_found,
                         o_glyph_index);
                mismatches++;
            end else begin
                exp_r = pending_glyphs.pop_front();
                if (o_found !== exp_r.found) begin
                    $display("%0t found: expected %0d actual %0d", $time, exp_r.found,
                             o_found);
                    mismatches++;
                end
                if (o_glyph_index !== exp_r.glyph) begin
                    $display("%0t glyph: expected %0d actual %0d", $time,
                             exp_r.glyph, o_glyph_index);
                    mismatches++;
                end
            end
        end
    end

    // range walk then binary search over the sparse codes
    function automatic t_glyph_res lookup_glyph(logic [15:0] code);
        t_glyph_res  r;
        int          nr;
        int          ns;
        int          lo;
        int          hi;
        int          mid;
        logic [31:0] total;
        logic [31:0] idx;
        logic [15:0] diff;
        bit          hit;
        r = '0;
        nr = (cnt_ranges > N_RANGES) ? N_RANGES : int'(cnt_ranges);
        ns = (cnt_sparse > N_SPARSE) ? N_SPARSE : int'(cnt_sparse);
        total = 32'd0;
        idx = 32'd0;
        hit = 1'b0;
        for (int k = 0; k < nr; k++) begin
            if (!hit) begin
                if (code >= tab_first[k] && code <= tab_last[k]) begin
                    diff = code - tab_first[k];
                    idx = total + {16'd0, diff};
                    hit = 1'b1;
                end else begin
                    total = total + {16'd0, tab_last[k]} - {16'd0, tab_first[k]} + 32'd1;
                end
            end
        end
        if (!hit && ns > 0) begin
            lo = 0;
            hi = ns - 1;
            while (lo <= hi && !hit) begin
                mid = lo + ((hi - lo) >>> 1);
                if (tab_sparse[mid] == code) begin
                    idx = total + 32'(mid);
                    hit = 1'b1;
                end else if (tab_sparse[mid] < code) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
        end
        if (hit && idx < {16'd0, cnt_glyphs}) begin
            r.found = 1'b1;
            r.glyph = idx[15:0];
        end
        return r;
    endfunction

    // apply an accepted beat to the shadow state and give its result
    function automatic t_glyph_res apply_beat(t_glyph_beat b);
        t_glyph_res r;
        r = '0;
        case (b.func)
            FUNC_RANGE: begin
                if (b.slot < N_RANGES) begin
                    tab_first[b.slot] = b.first;
                    tab_last[b.slot] = b.last;
                end
            end
            FUNC_SPARSE: begin
                tab_sparse[b.slot] = b.scode;
            end
            FUNC_LOOKUP: begin
                r = lookup_glyph(b.code);
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // beat builders; unused fields carry random noise
    function automatic t_glyph_beat noise_beat(logic [1:0] func);
        t_glyph_beat b;
        b.func = func;
        b.slot = 8'($urandom);
        b.first = 16'($urandom);
        b.last = 16'($urandom);
        b.scode = 16'($urandom);
        b.code = 16'($urandom);
        return b;
    endfunction

    function automatic t_glyph_beat range_beat(int slot, logic [15:0] first, logic [15:0] last);
        t_glyph_beat b;
        b = noise_beat(FUNC_RANGE);
        b.slot = 8'(slot);
        b.first = first;
        b.last = last;
        return b;
    endfunction

    function automatic t_glyph_beat sparse_beat(int slot, logic [15:0] scode);
        t_glyph_beat b;
        b = noise_beat(FUNC_SPARSE);
        b.slot = 8'(slot);
        b.scode = scode;
        return b;
    endfunction

    function automatic t_glyph_beat lookup_beat(logic [15:0] code);
        t_glyph_beat b;
        b = noise_beat(FUNC_LOOKUP);
        b.code = code;
        return b;
    endfunction

    // code point biased toward stored ranges and sparse codes
    function automatic logic [15:0] pick_code();
        int          sel;
        int          k;
        logic [15:0] code;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, N_RANGES - 1);
        if (sel < 40) begin
            code = tab_sparse[$urandom_range(0, N_SPARSE - 1)];
        end else if (sel < 75 && tab_first[k] <= tab_last[k]) begin
            code = tab_first[k] + 16'($urandom_range(0, int'(tab_last[k] - tab_first[k])));
        end else if (sel < 87) begin
            case ($urandom_range(0, 3))
                0: code = 16'h0000;
                1: code = 16'hffff;
                2: code = tab_first[k] - 16'd1;
                default: code = tab_last[k] + 16'd1;
            endcase
        end else begin
            code = 16'($urandom);
        end
        return code;
    endfunction

    // send one beat, hold it through stalls, record what it should give
    task automatic send_beat(t_glyph_beat b);
        while ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= b.func;
        i_entry_index <= b.slot;
        i_range_first <= b.first;
        i_range_last <= b.last;
        i_sparse_code <= b.scode;
        i_code_point <= b.code;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_glyphs.push_back(apply_beat(b));
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_glyphs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_RANGE_COUNT: cnt_ranges = data[4:0];
            CFG_SPARSE_COUNT: cnt_sparse = data[8:0];
            CFG_GLYPH_COUNT: cnt_glyphs = data;
            default: begin
            end
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_counts(int ranges, int sparse, int glyphs);
        wait_idle();
        write_reg(CFG_RANGE_COUNT, 16'(ranges));
        write_reg(CFG_SPARSE_COUNT, 16'(sparse));
        write_reg(CFG_GLYPH_COUNT, 16'(glyphs));
    endtask

    // fill both tables so nothing unwritten is ever read
    task automatic test_table_load();
        int first;
        int step;
        int code;
        for (int k = 0; k < N_RANGES; k++) begin
            first = k * 4096 + $urandom_range(0, 2000);
            send_beat(range_beat(k, 16'(first), 16'(first + $urandom_range(0, 300))));
        end
        code = $urandom_range(0, 50);
        for (int s = 0; s < N_SPARSE; s++) begin
            send_beat(sparse_beat(s, 16'(code)));
            step = $urandom_range(0, 250);
            code = (code + step > 65535) ? 65535 : code + step;
        end
    endtask

    // field extremes and every function code with full counts
    task automatic test_extremes();
        set_counts(N_RANGES, N_SPARSE, 16'hffff);
        send_beat(lookup_beat(16'h0000));
        send_beat(lookup_beat(16'hffff));
        send_beat(lookup_beat(tab_first[0]));
        send_beat(lookup_beat(tab_last[N_RANGES - 1]));
        send_beat(lookup_beat(tab_sparse[0]));
        send_beat(lookup_beat(tab_sparse[N_SPARSE / 2]));
        send_beat(lookup_beat(tab_sparse[N_SPARSE - 1]));
        // out-of-table range slots are dropped
        send_beat(range_beat(255, 16'h0000, 16'hffff));
        send_beat(range_beat(N_RANGES, 16'h0000, 16'hffff));
        send_beat(lookup_beat(16'h0000));
        send_beat(noise_beat(FUNC_NONE));
        send_beat(sparse_beat(N_SPARSE - 1, 16'hffff));
        send_beat(lookup_beat(16'hffff));
    endtask

    // oversized counts, zero glyphs, empty sparse table, reversed range
    task automatic test_count_cases();
        set_counts(31, 511, 0);
        send_beat(lookup_beat(tab_first[3]));
        send_beat(lookup_beat(tab_sparse[10]));
        set_counts(31, 511, 16'hffff);
        send_beat(lookup_beat(tab_first[3]));
        send_beat(lookup_beat(tab_sparse[10]));
        set_counts(N_RANGES, 0, 16'hffff);
        send_beat(lookup_beat(tab_sparse[20]));
        send_beat(lookup_beat(tab_last[7]));
        set_counts(N_RANGES, N_SPARSE, 100);
        send_beat(range_beat(2, 16'h9000, 16'h1000));
        send_beat(lookup_beat(tab_first[5]));
        send_beat(lookup_beat(tab_first[1]));
        send_beat(lookup_beat(tab_sparse[200]));
        set_counts(0, 1, 16'hffff);
        send_beat(lookup_beat(tab_sparse[0]));
        send_beat(lookup_beat(tab_first[0]));
    endtask

    function automatic t_glyph_beat random_beat();
        int sel;
        int first;
        int len;
        int slot;
        int lo_v;
        int hi_v;
        sel = $urandom_range(0, 99);
        if (sel < 65) begin
            return lookup_beat(pick_code());
        end else if (sel < 80) begin
            slot = ($urandom_range(0, 99) < 85) ? $urandom_range(0, N_RANGES - 1)
                                                : $urandom_range(N_RANGES, 255);
            case ($urandom_range(0, 6))
                0: return range_beat(slot, 16'($urandom), 16'($urandom));
                1: begin
                    first = $urandom_range(1, 65535);
                    return range_beat(slot, 16'(first), 16'($urandom_range(0, first - 1)));
                end
                default: begin
                    first = $urandom_range(0, 65535);
                    len = $urandom_range(0, 300);
                    if (first + len > 65535) first = 65535 - len;
                    return range_beat(slot, 16'(first), 16'(first + len));
                end
            endcase
        end else if (sel < 95) begin
            // mostly keep the sparse table in order
            slot = $urandom_range(0, N_SPARSE - 1);
            lo_v = (slot > 0) ? int'(tab_sparse[slot - 1]) : 0;
            hi_v = (slot < N_SPARSE - 1) ? int'(tab_sparse[slot + 1]) : 65535;
            if ($urandom_range(0, 99) < 80 && lo_v <= hi_v)
                return sparse_beat(slot, 16'($urandom_range(lo_v, hi_v)));
            return sparse_beat(slot, 16'($urandom));
        end
        return noise_beat(FUNC_NONE);
    endfunction

    // random phases, each after a full drain and a fresh setting
    task automatic test_random_phases();
        int ranges;
        int sparse;
        int glyphs;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(0, 5))
                0: ranges = 0;
                1: ranges = $urandom_range(N_RANGES + 1, 31);
                2: ranges = $urandom_range(1, N_RANGES);
                default: ranges = N_RANGES;
            endcase
            case ($urandom_range(0, 5))
                0: sparse = 0;
                1: sparse = $urandom_range(N_SPARSE + 1, 511);
                2: sparse = $urandom_range(1, N_SPARSE);
                default: sparse = N_SPARSE;
            endcase
            case ($urandom_range(0, 5))
                0: glyphs = 0;
                1: glyphs = $urandom_range(1, 400);
                2: glyphs = $urandom_range(0, 65535);
                default: glyphs = 65535;
            endcase
            set_counts(ranges, sparse, glyphs);
            for (int n = 0; n < 36; n++) send_beat(random_beat());
        end
    endtask

    // back-to-back beats with no idling on either side
    task automatic test_no_idle_stretch();
        set_counts(N_RANGES, N_SPARSE, 16'hffff);
        in_gap_pct = 0;
        out_stall_pct = 0;
        for (int n = 0; n < 150; n++) send_beat(random_beat());
        in_gap_pct = 8;
        out_stall_pct = 8;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_load();
        test_extremes();
        test_count_cases();
        test_no_idle_stretch();
        test_random_phases();
        wait_idle();
        if (mismatches == 0 && pending_glyphs.size() == 0) begin
            $display("PASS glyph_index_lookup");
        end else begin
            $display("FAIL glyph_index_lookup");
        end
        $finish;
    end

endmodule

### sim.f
rtl/gil_pkg.sv
rtl/gil_range_cell.sv
rtl/gil_search.sv
rtl/glyph_index_lookup.sv
verif/tb_top.sv
